FILE: rtl/priority_task_queue_assert.svh
// Assertion macros used by the priority task queue engine (ptq_engine).
`ifndef PRIORITY_TASK_QUEUE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PTQ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("priority_task_queue assertion failed");

// Check a same-cycle implication.
`define PTQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority_task_queue assertion failed");

// Check an implication in the next cycle.
`define PTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority_task_queue assertion failed");

`endif

FILE: rtl/ptq_pkg.sv
// Types, constants and helpers for the priority task queue.
package ptq_pkg;

  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned ADDR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned COUNT_FIELD_W = 5;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0] prio;
    logic [7:0] id;
  } entry_t;

  typedef struct packed {
    mode_e  mode;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    status_e                    status;
    entry_t                     head;
    logic [COUNT_FIELD_W-1:0]   cur_count;
    logic [COUNT_FIELD_W-1:0]   peak_count;
  } res_t;

  function automatic logic [COUNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[COUNT_FIELD_W-1:0];
  endfunction

endpackage

FILE: rtl/ptq_engine.sv
// Sequencer and entry store of the priority task queue: sorted insert and head removal.
`include "priority_task_queue_assert.svh"

module ptq_engine
  import ptq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  input  logic out_free_i,
  output logic ready_o,
  output logic done_o,
  output res_t res_o
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_PUSH_WALK = 6'b000010,
    ST_PUSH_INS  = 6'b000100,
    ST_POP_HEAD  = 6'b001000,
    ST_POP_WALK  = 6'b010000,
    ST_FINISH    = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   peak_q, peak_d;
  logic [CNT_W-1:0]   count_inc;
  entry_t             new_q, new_d;
  entry_t             head_q, head_d;
  status_e            status_q, status_d;

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_data_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic               mem_we;

  assign count_inc = count_q + CNT_W'(1);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    count_d  = count_q;
    peak_d   = peak_q;
    new_d    = new_q;
    head_d   = head_q;
    status_d = status_q;
    rd_addr  = '0;
    wr_addr  = idx_q;
    wr_data  = rd_data_q;
    mem_we   = 1'b0;
    done_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          new_d    = cmd_i.entry;
          head_d   = '0;
          status_d = STATUS_OK;
          if (cmd_i.mode == MODE_PUSH) begin
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = STATUS_FULL;
              state_d  = ST_FINISH;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = ST_PUSH_INS;
            end else begin
              idx_d   = ADDR_W'(count_q);
              rd_addr = ADDR_W'(count_q - CNT_W'(1));
              state_d = ST_PUSH_WALK;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_FINISH;
            end else begin
              idx_d   = '0;
              rd_addr = '0;
              state_d = ST_POP_HEAD;
            end
          end
        end
      end
      ST_PUSH_WALK: begin
        mem_we = 1'b1;
        if (rd_data_q.prio >= new_q.prio) begin
          wr_data = rd_data_q;
          idx_d   = idx_q - ADDR_W'(1);
          if (idx_q == ADDR_W'(1)) begin
            state_d = ST_PUSH_INS;
          end else begin
            rd_addr = idx_q - ADDR_W'(2);
          end
        end else begin
          wr_data = new_q;
          count_d = count_inc;
          peak_d  = (count_inc > peak_q) ? count_inc : peak_q;
          state_d = ST_FINISH;
        end
      end
      ST_PUSH_INS: begin
        mem_we  = 1'b1;
        wr_data = new_q;
        count_d = count_inc;
        peak_d  = (count_inc > peak_q) ? count_inc : peak_q;
        state_d = ST_FINISH;
      end
      ST_POP_HEAD: begin
        head_d  = rd_data_q;
        count_d = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          state_d = ST_FINISH;
        end else begin
          rd_addr = ADDR_W'(1);
          state_d = ST_POP_WALK;
        end
      end
      ST_POP_WALK: begin
        mem_we = 1'b1;
        idx_d  = idx_q + ADDR_W'(1);
        if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
          state_d = ST_FINISH;
        end else begin
          rd_addr = idx_q + ADDR_W'(2);
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      peak_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    new_q    <= new_d;
    head_q   <= head_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign ready_o          = (state_q == ST_IDLE);
  assign res_o.status     = status_q;
  assign res_o.head       = head_q;
  assign res_o.cur_count  = count_field(count_q);
  assign res_o.peak_count = count_field(peak_q);

  `PTQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH))
  `PTQ_ASSERT_ALWAYS(a_peak_covers, peak_q >= count_q)
  `PTQ_ASSERT_IMPL(a_write_busy, mem_we, (state_q != ST_IDLE) && (state_q != ST_FINISH))
  `PTQ_ASSERT_NEXT(a_start_busy, start_i && ready_o, !ready_o)

endmodule

FILE: rtl/priority_task_queue.sv
// Top level of the priority task queue: stream ports and result register.
//
// Slave channel (s_axis): one transaction is one command. tuser selects push (0) or
// pop (1); tdata carries the task id and its priority (smaller value served first).
// Master channel (m_axis): one transaction per command, in command order, with the
// status in tuser and the popped entry plus current and peak counts in tdata.
// A command is taken only while the sequencer is idle. A push walks the stored
// entries from the tail, one entry per cycle through the store's one read and one
// write port, until its slot is found; a pop reads the head and moves every
// remaining entry up one slot. Either presents its result when its store work ends,
// a full push or an empty pop goes straight to its result, and the next command is
// taken only after the result is handed off to the result register.
// Reset empties the queue and clears both counts; the store itself is not cleared.
// The result register holds a finished transaction while m_axis_tready is low; the
// next command may be accepted meanwhile, but its result waits for the register.
module priority_task_queue
  import ptq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] task_id, [11:8] priority_req, [15:12] zero
  input  logic [0:0]  s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] head_task, [11:8] head_priority,
                                     // [16:12] current_count, [21:17] peak_count,
                                     // [23:22] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  cmd_t cmd;
  res_t res;
  logic start;
  logic ready;
  logic done;
  logic out_free;
  logic m_valid_q;
  res_t m_res_q;

  assign cmd.mode  = mode_e'(s_axis_tuser[0]);
  assign cmd.entry = '{prio: s_axis_tdata[11:8], id: s_axis_tdata[7:0]};
  assign start     = s_axis_tvalid && ready;
  assign out_free  = !m_valid_q || m_axis_tready;

  ptq_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (cmd),
    .out_free_i (out_free),
    .ready_o    (ready),
    .done_o     (done),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      m_res_q <= res;
    end
  end

  assign s_axis_tready = ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {2'b00, m_res_q.peak_count, m_res_q.cur_count,
                          m_res_q.head.prio, m_res_q.head.id};

endmodule

FILE: test/priority_task_queue_test.sv
// Self-checking stream testbench for the priority task queue: directed table then random traffic.
`timescale 1ns / 100ps

module priority_task_queue_test
  import ptq_pkg::*;
();

  localparam int unsigned RAND_ITEMS = 927;

  typedef struct {
    mode_e      mode;
    logic [7:0] id;
    logic [3:0] prio;
    bit         typed;
    res_t       want;
  } cmd_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic [7:0]  shadow_ids   [QUEUE_DEPTH];
  logic [3:0]  shadow_prios [QUEUE_DEPTH];
  int unsigned shadow_count = 0;
  int unsigned shadow_peak  = 0;

  res_t        pending_results [$];
  cmd_row_t    table_rows [$];
  bit          row_typed    = 1'b0;
  res_t        row_want     = '0;
  bit          sink_steady  = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned mismatch_count = 0;

  priority_task_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic apply_queue_cmd(input mode_e mode, input logic [7:0] id,
                                 input logic [3:0] prio, output res_t r);
    int unsigned slot;
    int unsigned k;
    r = '0;
    if (mode == MODE_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        slot = 0;
        while (slot < shadow_count && shadow_prios[slot] < prio) slot++;
        for (k = shadow_count; k > slot; k--) begin
          shadow_ids[k]   = shadow_ids[k-1];
          shadow_prios[k] = shadow_prios[k-1];
        end
        shadow_ids[slot]   = id;
        shadow_prios[slot] = prio;
        shadow_count++;
        if (shadow_count > shadow_peak) shadow_peak = shadow_count;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.head.id   = shadow_ids[0];
        r.head.prio = shadow_prios[0];
        for (k = 1; k < shadow_count; k++) begin
          shadow_ids[k-1]   = shadow_ids[k];
          shadow_prios[k-1] = shadow_prios[k];
        end
        shadow_count--;
      end
    end
    r.cur_count  = COUNT_FIELD_W'(shadow_count);
    r.peak_count = COUNT_FIELD_W'(shadow_peak);
  endtask

  always @(posedge clk_i) begin : accept_monitor
    res_t predicted;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      apply_queue_cmd(mode_e'(s_axis_tuser[0]), s_axis_tdata[7:0], s_axis_tdata[11:8],
                      predicted);
      pending_results.push_back(row_typed ? row_want : predicted);
    end
  end

  always @(posedge clk_i) begin : result_checker
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[7:0] != want.head.id)
          report_mismatch("head_task", m_axis_tdata[7:0], want.head.id);
        if (m_axis_tdata[11:8] != want.head.prio)
          report_mismatch("head_priority", m_axis_tdata[11:8], want.head.prio);
        if (m_axis_tdata[16:12] != want.cur_count)
          report_mismatch("current_count", m_axis_tdata[16:12], want.cur_count);
        if (m_axis_tdata[21:17] != want.peak_count)
          report_mismatch("peak_count", m_axis_tdata[21:17], want.peak_count);
      end
    end
  end

  always @(posedge clk_i) begin : sink_pacing
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!sink_steady && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic add_row(input mode_e mode, input logic [7:0] id, input logic [3:0] prio,
                         input bit typed, input status_e status, input logic [7:0] head_id,
                         input logic [3:0] head_prio, input logic [4:0] cur,
                         input logic [4:0] peak);
    cmd_row_t row;
    row.mode              = mode;
    row.id                = id;
    row.prio              = prio;
    row.typed             = typed;
    row.want.status       = status;
    row.want.head.id      = head_id;
    row.want.head.prio    = head_prio;
    row.want.cur_count    = cur;
    row.want.peak_count   = peak;
    table_rows.push_back(row);
  endtask

  task automatic send_cmd(input mode_e mode, input logic [7:0] id, input logic [3:0] prio,
                          input bit typed, input res_t want, input bit quiet);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, prio, id};
    s_axis_tuser  <= mode;
    row_typed     <= typed;
    row_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit          fill_phase;
    int unsigned phase_left;
    bit          quiet;
    mode_e       mode;
    logic [3:0]  prio;

    add_row(MODE_POP,  8'h00, 4'h0, 1, STATUS_EMPTY, 8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h00, 4'h0, 1, STATUS_OK,    8'h00, 4'h0, 5'd1,  5'd1);
    add_row(MODE_POP,  8'hFF, 4'hF, 1, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd1);
    add_row(MODE_PUSH, 8'hFF, 4'hF, 1, STATUS_OK,    8'h00, 4'h0, 5'd1,  5'd1);
    add_row(MODE_PUSH, 8'h5A, 4'hF, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'hA5, 4'h0, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h33, 4'h7, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_POP,  8'h00, 4'h0, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h01, 4'h8, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h02, 4'h3, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h03, 4'hF, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h04, 4'h0, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h05, 4'h7, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h06, 4'hC, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h07, 4'h1, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h08, 4'hE, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h09, 4'h7, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h0A, 4'h4, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h0B, 4'h9, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h0C, 4'h2, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h0D, 4'hB, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);
    add_row(MODE_PUSH, 8'h80, 4'h5, 1, STATUS_FULL,  8'h00, 4'h0, 5'd16, 5'd16);
    add_row(MODE_POP,  8'h00, 4'h0, 0, STATUS_OK,    8'h00, 4'h0, 5'd0,  5'd0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_cmd(table_rows[i].mode, table_rows[i].id, table_rows[i].prio,
               table_rows[i].typed, table_rows[i].want, 1'b0);
    wait_drained();

    fill_phase = 1'b0;
    phase_left = 0;
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        fill_phase = !fill_phase;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      quiet = (n >= 400 && n < 480) || (n + 120 >= RAND_ITEMS);
      sink_steady <= quiet;
      if (n == 600) wait_drained();
      mode = ($urandom_range(0, 99) < (fill_phase ? 75 : 25)) ? MODE_PUSH : MODE_POP;
      prio = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      send_cmd(mode, 8'($urandom_range(0, 255)), prio, 1'b0, '0, quiet);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: priority_task_queue.f
+incdir+rtl
rtl/ptq_pkg.sv
rtl/ptq_engine.sv
rtl/priority_task_queue.sv
test/priority_task_queue_test.sv
